// File: rtl/scba_pkg.sv
// shared types and fixed field widths for the size class block allocator
package scba_pkg;

    localparam int SIZE_W    = 12;
    localparam int ADDR_W    = 20;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BADSIZE   = 2'd1,
        STAT_EXHAUSTED = 2'd2,
        STAT_BADFREE   = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_LINK,
        S_REM
    } state_t;

endpackage

// File: rtl/scba_head_table.sv
// free list head table with per-class valid bits and a registered read
module scba_head_table #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DATA_W = 18
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // a class never written reads as an empty list
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/scba_link_ram.sv
// link word memory, one write and one registered read port
module scba_link_ram #(
    parameter int DEPTH  = 131072,
    parameter int AW     = 17,
    parameter int DATA_W = 18
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/size_class_block_allocator_core.sv
// Size class block allocator: each transfer on the slave side is one allocate or free request
// and gives exactly one transfer on the master side. Frees, rejected requests and plain bump
// allocations go from acceptance to result through the head table read and then the update; a pop
// from a nonempty list and a chunk change that pushes the old remainder add the S_LINK or S_REM
// state, since the head table read is followed by a second read of the link memory or of the
// remainder's class head. One request is in flight at a time, so a new request is accepted only
// after the last one has finished and while the holding slot is free or draining; a finished result
// waits in the output register while the next request is accepted. The head table has valid bits cleared
// at reset, so no clearing pass is needed and requests are accepted right after reset.
module size_class_block_allocator_core #(
    parameter int ARENA_BYTES     = 1048576,
    parameter int CHUNK_BYTES     = 16384,
    parameter int MAX_BLOCK_BYTES = 516,
    parameter int ALIGN_BYTES     = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [scba_pkg::S_TDATA_W-1:0]  s_tdata,  // [11:0] size_bytes, [31:12] block_address
    input  logic                            s_tuser,  // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [scba_pkg::M_TDATA_W-1:0]  m_tdata,  // [19:0] result_address, [23:20] zero
    output logic [scba_pkg::STATUS_W-1:0]   m_tuser   // [1:0] status
);
    import scba_pkg::*;

    localparam int SH          = $clog2(ALIGN_BYTES);
    localparam int NUM_CLASSES = MAX_BLOCK_BYTES / ALIGN_BYTES;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int LINK_DEPTH  = (ARENA_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int IDX_W       = $clog2(LINK_DEPTH);
    localparam int HEAD_W      = $clog2(LINK_DEPTH + 1);
    localparam int CHUNK_RAW   = (CHUNK_BYTES < MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : CHUNK_BYTES;
    localparam int CHUNK_SPAN  = (CHUNK_RAW + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    localparam int PTR_W       = $clog2(ARENA_BYTES + 1);
    localparam int REM_W       = $clog2(CHUNK_SPAN + 1);
    localparam int RSIZE_W     = SIZE_W + 1;
    localparam int RCMP_W      = (REM_W > RSIZE_W) ? REM_W : RSIZE_W;
    localparam int ACMP_W      = (PTR_W > ADDR_W) ? PTR_W : ADDR_W;

    // control and pointer state
    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    bump_reg, bump_next;
    logic [PTR_W-1:0]    used_top_reg, used_top_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                pend_vld_reg, pend_vld_next;

    // request and result payload
    opcode_t             op_reg;
    logic [RSIZE_W-1:0]  rsize_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [ADDR_W-1:0]   m_addr_reg, pend_addr_reg;
    status_t             m_status_reg, pend_status_reg;

    // memory ports
    logic                head_wr_en, head_rd_en;
    logic [CLS_W-1:0]    head_wr_addr, head_rd_addr;
    logic [HEAD_W-1:0]   head_wr_data, head_q;
    logic                link_wr_en, link_rd_en;
    logic [IDX_W-1:0]    link_wr_addr, link_rd_addr;
    logic [HEAD_W-1:0]   link_wr_data, link_q;

    // decode
    logic                s_accept, out_free;
    logic [RSIZE_W-1:0]  in_rsize;
    logic [CLS_W-1:0]    in_cls;
    logic                size_bad, free_bad, head_hit, need_chunk, exhausted, rem_push;
    logic                go_link, go_rem;
    logic [PTR_W:0]      top_plus_span;
    logic [CLS_W-1:0]    rem_cls;
    logic [IDX_W-1:0]    free_idx, bump_idx, pop_idx;

    // finishing result
    logic                fin;
    logic [ADDR_W-1:0]   fin_addr;
    status_t             fin_status;

    scba_head_table #(
        .DEPTH  (NUM_CLASSES),
        .AW     (CLS_W),
        .DATA_W (HEAD_W)
    ) u_heads (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (head_wr_en),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_en   (head_rd_en),
        .rd_addr (head_rd_addr),
        .rd_data (head_q)
    );

    scba_link_ram #(
        .DEPTH  (LINK_DEPTH),
        .AW     (IDX_W),
        .DATA_W (HEAD_W)
    ) u_links (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_q)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && (!pend_vld_reg || out_free);
    assign s_accept = s_tvalid && s_tready;

    assign in_rsize = (RSIZE_W'(s_tdata[SIZE_W-1:0]) + RSIZE_W'(ALIGN_BYTES - 1))
                      & ~RSIZE_W'(ALIGN_BYTES - 1);
    assign in_cls   = CLS_W'((in_rsize >> SH) - 1'b1);

    always_comb begin
        size_bad      = (rsize_reg == '0) || (rsize_reg > RSIZE_W'(MAX_BLOCK_BYTES));
        free_bad      = (ACMP_W'(addr_reg) >= ACMP_W'(used_top_reg))
                        || ((addr_reg & ADDR_W'(ALIGN_BYTES - 1)) != '0);
        head_hit      = (head_q != '0);
        need_chunk    = RCMP_W'(rem_reg) < RCMP_W'(rsize_reg);
        top_plus_span = (PTR_W+1)'(used_top_reg) + (PTR_W+1)'(CHUNK_SPAN);
        exhausted     = top_plus_span > (PTR_W+1)'(ARENA_BYTES);
        rem_push      = rem_reg >= REM_W'(ALIGN_BYTES);
        rem_cls       = CLS_W'((rem_reg >> SH) - 1'b1);
        free_idx      = IDX_W'(addr_reg >> SH);
        bump_idx      = IDX_W'(bump_reg >> SH);
        pop_idx       = IDX_W'(head_q - 1'b1);
        go_link       = (op_reg == OP_ALLOC) && !size_bad && head_hit;
        go_rem        = (op_reg == OP_ALLOC) && !size_bad && !head_hit && need_chunk
                        && !exhausted && rem_push;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                if (go_link) begin
                    state_next = S_LINK;
                end else if (go_rem) begin
                    state_next = S_REM;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LINK:  state_next = S_IDLE;
            S_REM:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory accesses, pointer updates and result
    always_comb begin
        head_rd_en    = 1'b0;
        head_rd_addr  = in_cls;
        head_wr_en    = 1'b0;
        head_wr_addr  = cls_reg;
        head_wr_data  = link_q;
        link_rd_en    = 1'b0;
        link_rd_addr  = pop_idx;
        link_wr_en    = 1'b0;
        link_wr_addr  = free_idx;
        link_wr_data  = head_q;
        bump_next     = bump_reg;
        used_top_next = used_top_reg;
        rem_next      = rem_reg;
        fin           = 1'b0;
        fin_addr      = '0;
        fin_status    = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                head_rd_en = s_accept;
            end
            S_HEAD: begin
                if (op_reg == OP_FREE) begin
                    fin = 1'b1;
                    if (free_bad) begin
                        fin_status = STAT_BADFREE;
                    end else if (size_bad) begin
                        fin_status = STAT_BADSIZE;
                    end else begin
                        // push the freed block on its class list
                        link_wr_en   = 1'b1;
                        head_wr_en   = 1'b1;
                        head_wr_data = HEAD_W'(free_idx) + 1'b1;
                    end
                end else if (size_bad) begin
                    fin        = 1'b1;
                    fin_status = STAT_BADSIZE;
                end else if (head_hit) begin
                    link_rd_en = 1'b1;
                end else if (!need_chunk) begin
                    fin       = 1'b1;
                    fin_addr  = ADDR_W'(bump_reg);
                    bump_next = bump_reg + PTR_W'(rsize_reg);
                    rem_next  = rem_reg - REM_W'(rsize_reg);
                end else if (exhausted) begin
                    fin        = 1'b1;
                    fin_status = STAT_EXHAUSTED;
                end else if (rem_push) begin
                    head_rd_en   = 1'b1;
                    head_rd_addr = rem_cls;
                end else begin
                    fin           = 1'b1;
                    fin_addr      = ADDR_W'(used_top_reg);
                    bump_next     = used_top_reg + PTR_W'(rsize_reg);
                    used_top_next = PTR_W'(top_plus_span);
                    rem_next      = REM_W'(CHUNK_SPAN) - REM_W'(rsize_reg);
                end
            end
            S_LINK: begin
                // pop: the head moves to the next block in the list
                head_wr_en = 1'b1;
                fin        = 1'b1;
                fin_addr   = ADDR_W'({pop_idx, {SH{1'b0}}});
            end
            S_REM: begin
                // old chunk tail goes on its class list, then a new chunk is taken
                link_wr_en    = 1'b1;
                link_wr_addr  = bump_idx;
                head_wr_en    = 1'b1;
                head_wr_addr  = rem_cls;
                head_wr_data  = HEAD_W'(bump_idx) + 1'b1;
                fin           = 1'b1;
                fin_addr      = ADDR_W'(used_top_reg);
                bump_next     = used_top_reg + PTR_W'(rsize_reg);
                used_top_next = PTR_W'(top_plus_span);
                rem_next      = REM_W'(CHUNK_SPAN) - REM_W'(rsize_reg);
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // output register with one holding slot behind it
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pend_vld_next = pend_vld_reg;
        if (pend_vld_reg && out_free) begin
            m_tvalid_next = 1'b1;
            pend_vld_next = 1'b0;
        end
        if (fin) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
            end else begin
                pend_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bump_reg     <= '0;
            used_top_reg <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bump_reg     <= bump_next;
            used_top_reg <= used_top_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= opcode_t'(s_tuser);
            rsize_reg <= in_rsize;
            addr_reg  <= s_tdata[SIZE_W +: ADDR_W];
            cls_reg   <= in_cls;
        end
        if (pend_vld_reg && out_free) begin
            m_addr_reg   <= pend_addr_reg;
            m_status_reg <= pend_status_reg;
        end
        if (fin) begin
            if (out_free) begin
                m_addr_reg   <= fin_addr;
                m_status_reg <= fin_status;
            end else begin
                pend_addr_reg   <= fin_addr;
                pend_status_reg <= fin_status;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_addr_reg);
    assign m_tuser  = m_status_reg;

    // a result is held back only while the output register is occupied
    a_pend_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_vld_reg |-> m_tvalid_reg)
        else $error("held result while output register empty");

    // the current chunk always ends at the arena top
    a_chunk_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (PTR_W+1)'(bump_reg) + (PTR_W+1)'(rem_reg) == (PTR_W+1)'(used_top_reg))
        else $error("bump pointer and remainder disagree with arena top");

    // no head table read may overlap a write of the same class
    a_head_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(head_wr_en && head_rd_en && (head_wr_addr == head_rd_addr)))
        else $error("head table read and write collide");

    // an accepted request goes straight to the head lookup and blocks the input
    a_accept_leads_head: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_HEAD) && !s_tready)
        else $error("request not taken into head lookup");

endmodule
